### hw/rtl/dual_track_skip_step_sequencer_macros.svh
// assertion helpers for the step sequencer
`ifndef DUAL_TRACK_SKIP_STEP_SEQUENCER_MACROS_SVH
`define DUAL_TRACK_SKIP_STEP_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define DTSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dtss assertion failed");
// next-cycle implication
`define DTSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dtss assertion failed");
`else
`define DTSS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define DTSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hw/rtl/dtss_pkg.sv
package dtss_pkg;

  localparam int MAX_STEPS_DEF = 16;

  localparam int LEN_W = 5;
  localparam int KIND_W = 3;
  localparam int CNT_W = 3;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [LEN_W-1:0] len_t;

  localparam kind_t KIND_EMPTY = 3'd0;
  localparam kind_t KIND_PLAIN = 3'd1;
  localparam kind_t KIND_SKIP_MIN = 3'd2;
  localparam kind_t KIND_SKIP_MAX = 3'd5;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_EDIT = 1'b1;

  // register select is address bit 2
  localparam logic REG_LEN_A = 1'b0;
  localparam logic REG_LEN_B = 1'b1;

  localparam len_t LEN_A_RST = 5'd5;
  localparam len_t LEN_B_RST = 5'd6;

  function automatic logic is_skip_kind(input kind_t k);
    return k inside {[KIND_SKIP_MIN:KIND_SKIP_MAX]};
  endfunction

endpackage

### hw/rtl/dual_track_skip_step_sequencer.sv
// Two-track gate step sequencer with skip steps.
// Input channel (in_valid/in_ready): one item per cycle while in_ready is high, either a tick sample
// (in_cmd tick: clock level plus optional reset pulse) or a step edit
// (in_cmd edit: track, step index, kind). Each item gives exactly one result
// item on the output channel (out_valid/out_ready) carrying both gate levels
// after the item has been applied.
// The result is registered in the output register, or in the skid register while the output is stalled.
// Throughput: one item per cycle while in_ready is high; all step state is read and
// written in the same cycle per track, one step per track per item.
// A two-deep output buffer (output register plus skid register) keeps the
// input open while one result waits; in_ready drops only when both hold
// results, i.e. after the receiver has stalled for two items.
// Track lengths are set through the APB port (len A at 0x0, len B at 0x4),
// a length of 0 acts as 1 and lengths above the step store are clipped.
// Reset (rst_n low, synchronous) empties every step, clears positions,
// counters and gates, restores lengths 5 and 6 and drops out_valid; the
// block takes items in the first cycle after reset.
`include "dual_track_skip_step_sequencer_macros.svh"

module dual_track_skip_step_sequencer
  import dtss_pkg::*;
#(
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  input  logic              in_clock_level,
  input  logic              in_reset_pulse,
  input  logic              in_edit_track,
  input  logic [3:0]        in_edit_step,
  input  logic [2:0]        in_edit_kind,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_gate_a,
  output logic              out_gate_b,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int PW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int CW = (PW + 1 > LEN_W) ? PW + 1 : LEN_W;
  localparam logic [CW-1:0] STEPS_C = CW'(MAX_STEPS);

  // configuration
  len_t len_a_r;
  len_t len_b_r;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_a_r <= LEN_A_RST;
      len_b_r <= LEN_B_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_LEN_A: len_a_r <= pwdata[LEN_W-1:0];
        REG_LEN_B: len_b_r <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_LEN_A: prdata = DATA_W'(len_a_r);
      REG_LEN_B: prdata = DATA_W'(len_b_r);
      default:   prdata = '0;
    endcase
  end

  // input decode shared by both tracks
  logic          acc_in;
  logic          acc_out;
  logic [CW-1:0] edit_idx;
  logic          edit_ok;
  kind_t         kind_fix;

  assign acc_in   = in_valid & in_ready;
  assign edit_idx = CW'(in_edit_step);
  assign edit_ok  = edit_idx < STEPS_C;
  assign kind_fix = (in_edit_kind == KIND_EMPTY || in_edit_kind > KIND_SKIP_MAX) ?
                    KIND_PLAIN : in_edit_kind;

  wire [1:0] gate_now;
  wire [1:0] gate_cur;
  wire [1:0] pos_zero;

  for (genvar t = 0; t < 2; t++) begin : g_trk
    kind_t           kind_r [MAX_STEPS];
    logic [MAX_STEPS-1:0] act_r;
    cnt_t            cnt_r [MAX_STEPS];
    logic [PW-1:0]   pos_r;
    logic [PW-1:0]   pos_nxt;
    logic            edge_r;
    logic            edge_nxt;
    logic            gate_r;
    logic            gate_nxt;

    logic [CW-1:0]   len_eff;
    logic [CW-1:0]   adv_w;
    logic [PW-1:0]   rd_idx;
    kind_t           rd_kind;
    logic            rd_act;
    cnt_t            rd_cnt;
    logic            edit_hit;

    logic            wr_en;
    logic [PW-1:0]   wr_idx;
    kind_t           wr_kind;
    logic            wr_act;
    cnt_t            wr_cnt;

    always_comb begin
      len_eff = CW'((t == 0) ? len_a_r : len_b_r);
      if (len_eff == '0) begin
        len_eff = CW'(1);
      end else if (len_eff > STEPS_C) begin
        len_eff = STEPS_C;
      end
      adv_w = CW'(pos_r) + CW'(1);
      // a shrunk length below the position wraps too
      if (adv_w >= len_eff) begin
        adv_w = '0;
      end
    end

    // advance and edit never meet in one item, so one read port serves both
    assign rd_idx   = (in_cmd == CMD_EDIT) ? edit_idx[PW-1:0] : adv_w[PW-1:0];
    assign rd_kind  = kind_r[rd_idx];
    assign rd_act   = act_r[rd_idx];
    assign rd_cnt   = cnt_r[rd_idx];
    assign edit_hit = (in_cmd == CMD_EDIT) && (in_edit_track == 1'(t)) && edit_ok;

    always_comb begin
      pos_nxt  = pos_r;
      edge_nxt = edge_r;
      gate_nxt = gate_r;
      wr_en    = 1'b0;
      wr_idx   = rd_idx;
      wr_kind  = rd_kind;
      wr_act   = rd_act;
      wr_cnt   = rd_cnt;
      if (acc_in && in_cmd == CMD_TICK) begin
        if (in_reset_pulse) begin
          pos_nxt  = '0;
          edge_nxt = 1'b1;
          gate_nxt = 1'b0;
          if (kind_r[0] == KIND_PLAIN) begin
            gate_nxt = act_r[0];
          end else if (is_skip_kind(kind_r[0]) && act_r[0]) begin
            gate_nxt = 1'b1;
            wr_en    = 1'b1;
            wr_idx   = '0;
            wr_kind  = kind_r[0];
            wr_act   = 1'b1;
            wr_cnt   = '0;
          end
        end
        if (!in_clock_level) begin
          gate_nxt = 1'b0;
          edge_nxt = 1'b0;
        end else if (!edge_nxt) begin
          pos_nxt  = adv_w[PW-1:0];
          edge_nxt = 1'b1;
          if (rd_kind == KIND_PLAIN) begin
            if (rd_act) begin
              gate_nxt = 1'b1;
            end
          end else if (is_skip_kind(rd_kind)) begin
            wr_en = 1'b1;
            // fires on every nth visit
            if (rd_cnt >= rd_kind - 3'd1) begin
              wr_cnt   = '0;
              wr_act   = 1'b1;
              gate_nxt = 1'b1;
            end else begin
              wr_act = 1'b0;
              wr_cnt = rd_cnt + 3'd1;
            end
          end
        end
      end else if (acc_in && edit_hit) begin
        wr_en = 1'b1;
        wr_cnt = '0;
        if (!rd_act && rd_cnt == '0) begin
          wr_kind = kind_fix;
          wr_act  = 1'b1;
        end else begin
          wr_kind = KIND_EMPTY;
          wr_act  = 1'b0;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        for (int i = 0; i < MAX_STEPS; i++) begin
          kind_r[i] <= KIND_EMPTY;
          cnt_r[i]  <= '0;
        end
        act_r  <= '0;
        pos_r  <= '0;
        edge_r <= 1'b0;
        gate_r <= 1'b0;
      end else begin
        pos_r  <= pos_nxt;
        edge_r <= edge_nxt;
        gate_r <= gate_nxt;
        if (wr_en) begin
          kind_r[wr_idx] <= wr_kind;
          act_r[wr_idx]  <= wr_act;
          cnt_r[wr_idx]  <= wr_cnt;
        end
      end
    end

    assign gate_now[t] = gate_nxt;
    assign gate_cur[t] = gate_r;
    assign pos_zero[t] = (pos_r == '0);
  end

  // output register plus skid register
  logic       out_valid_r;
  logic [1:0] out_data_r;
  logic       skid_valid_r;
  logic [1:0] skid_data_r;
  logic       out_load;

  assign in_ready   = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_gate_a = out_data_r[0];
  assign out_gate_b = out_data_r[1];
  assign acc_out    = out_valid_r & out_ready;
  assign out_load   = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_load) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= acc_in;
      end else begin
        out_valid_r  <= acc_in;
      end
    end else if (acc_in) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (skid_valid_r) begin
        out_data_r  <= skid_data_r;
        skid_data_r <= gate_now;
      end else begin
        out_data_r <= gate_now;
      end
    end else if (acc_in) begin
      skid_data_r <= gate_now;
    end
  end

  `DTSS_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  `DTSS_ASSERT_NEXT(a_drain_keeps_valid, clk, rst_n, acc_out && skid_valid_r, out_valid_r)
  `DTSS_ASSERT_NEXT(a_reset_pulse_home, clk, rst_n,
    acc_in && in_cmd == CMD_TICK && in_reset_pulse, pos_zero == 2'b11)
  `DTSS_ASSERT_NEXT(a_edit_keeps_gates, clk, rst_n, acc_in && in_cmd == CMD_EDIT,
    $stable(gate_cur))

endmodule

### dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import dtss_pkg::*;

  localparam logic TRACK_A = 1'b0;
  localparam logic TRACK_B = 1'b1;
  localparam kind_t KIND_SKIP3 = 3'd3;
  localparam kind_t KIND_SKIP4 = 3'd4;
  localparam kind_t KIND_BAD6 = 3'd6;
  localparam kind_t KIND_BAD7 = 3'd7;

  typedef enum int {RX_OPEN, RX_COIN, RX_TIGHT, RX_PERIODIC} rx_mode_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_cmd = CMD_TICK;
  logic              in_clock_level = 1'b0;
  logic              in_reset_pulse = 1'b0;
  logic              in_edit_track = 1'b0;
  logic [3:0]        in_edit_step = 4'd0;
  logic [2:0]        in_edit_kind = 3'd0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_gate_a;
  logic              out_gate_b;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  dual_track_skip_step_sequencer dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cmd(in_cmd),
    .in_clock_level(in_clock_level),
    .in_reset_pulse(in_reset_pulse),
    .in_edit_track(in_edit_track),
    .in_edit_step(in_edit_step),
    .in_edit_kind(in_edit_kind),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_gate_a(out_gate_a),
    .out_gate_b(out_gate_b),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // sequencer state as predicted
  kind_t      slot_kind [2][MAX_STEPS_DEF];
  logic       slot_armed [2][MAX_STEPS_DEF];
  cnt_t       slot_count [2][MAX_STEPS_DEF];
  logic [3:0] play_pos [2];
  logic       edge_seen [2];
  logic       gate_lvl [2];
  len_t       track_len_reg [2];

  // {gate_a, gate_b} per accepted item, oldest first
  logic [1:0] gate_queue [$];

  int errors = 0;
  int results_seen = 0;
  int ticks_sent = 0;
  int edits_sent = 0;
  int resets_sent = 0;
  int length_writes = 0;
  int burst_left = 0;
  logic last_level = 1'b0;

  function automatic int eff_len(input int t);
    int n;
    n = track_len_reg[t];
    if (n < 1) n = 1;
    if (n > MAX_STEPS_DEF) n = MAX_STEPS_DEF;
    return n;
  endfunction

  function automatic void rewind_track(input int t);
    kind_t k;
    k = slot_kind[t][0];
    edge_seen[t] = 1'b1;
    play_pos[t] = 4'd0;
    gate_lvl[t] = 1'b0;
    if (k == KIND_PLAIN) begin
      gate_lvl[t] = slot_armed[t][0];
    end else if (k >= KIND_SKIP_MIN && k <= KIND_SKIP_MAX && slot_armed[t][0]) begin
      slot_count[t][0] = '0;
      gate_lvl[t] = 1'b1;
    end
  endfunction

  function automatic void strike_track(input int t, input logic high);
    int p;
    kind_t k;
    if (!high) begin
      gate_lvl[t] = 1'b0;
      edge_seen[t] = 1'b0;
      return;
    end
    if (edge_seen[t]) return;
    p = int'(play_pos[t]) + 1;
    if (p >= eff_len(t)) p = 0;
    play_pos[t] = 4'(p);
    k = slot_kind[t][p];
    if (k == KIND_PLAIN) begin
      if (slot_armed[t][p]) gate_lvl[t] = 1'b1;
    end else if (k >= KIND_SKIP_MIN && k <= KIND_SKIP_MAX) begin
      // skip step fires on every nth visit only
      if (int'(slot_count[t][p]) >= int'(k) - 1) begin
        slot_count[t][p] = '0;
        slot_armed[t][p] = 1'b1;
        gate_lvl[t] = 1'b1;
      end else begin
        slot_armed[t][p] = 1'b0;
        slot_count[t][p] = slot_count[t][p] + 3'd1;
      end
    end
    edge_seen[t] = 1'b1;
  endfunction

  function automatic void step_gates(input logic cmd, input logic lvl, input logic rp,
                                     input logic trk, input logic [3:0] step,
                                     input logic [2:0] kind);
    kind_t k;
    int s;
    int t;
    if (cmd == CMD_TICK) begin
      if (rp) begin
        rewind_track(0);
        rewind_track(1);
      end
      strike_track(0, lvl);
      strike_track(1, lvl);
    end else begin
      k = kind;
      if (k == KIND_EMPTY || k > KIND_SKIP_MAX) k = KIND_PLAIN;
      s = step;
      t = trk;
      if (s < MAX_STEPS_DEF) begin
        if (!slot_armed[t][s] && slot_count[t][s] == '0) begin
          slot_kind[t][s] = k;
          slot_armed[t][s] = 1'b1;
        end else begin
          slot_kind[t][s] = KIND_EMPTY;
          slot_armed[t][s] = 1'b0;
        end
        slot_count[t][s] = '0;
      end
    end
  endfunction

  // result check first, then prediction for the item taken at this edge
  always @(posedge clk) begin : monitor
    logic [1:0] want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (gate_queue.size() == 0) begin
          $display("%0t: unexpected result, expected none, got gate_a=%b gate_b=%b",
                   $time, out_gate_a, out_gate_b);
          errors++;
        end else begin
          want = gate_queue.pop_front();
          if (out_gate_a !== want[1]) begin
            $display("%0t: gate_a expected %b got %b", $time, want[1], out_gate_a);
            errors++;
          end
          if (out_gate_b !== want[0]) begin
            $display("%0t: gate_b expected %b got %b", $time, want[0], out_gate_b);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        step_gates(in_cmd, in_clock_level, in_reset_pulse, in_edit_track, in_edit_step,
                   in_edit_kind);
        gate_queue.push_back({gate_lvl[0], gate_lvl[1]});
      end
    end
  end

  // receiver back-pressure, switching between patterns
  rx_mode_t rx_mode = RX_OPEN;
  int rx_left = 0;
  int rx_cyc = 0;

  always @(posedge clk) begin
    rx_cyc++;
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(32, 256);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN: begin
        out_ready <= 1'b1;
      end
      RX_COIN: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      RX_TIGHT: begin
        out_ready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_ready <= ((rx_cyc % 5) < 2);
      end
    endcase
  end

  task automatic send_item(input logic cmd, input logic lvl, input logic rp, input logic trk,
                           input logic [3:0] step, input logic [2:0] kind);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_clock_level <= lvl;
    in_reset_pulse <= rp;
    in_edit_track <= trk;
    in_edit_step <= step;
    in_edit_kind <= kind;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic tick(input logic lvl, input logic rp);
    ticks_sent++;
    if (rp) resets_sent++;
    last_level = lvl;
    send_item(CMD_TICK, lvl, rp, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
              3'($urandom_range(0, 7)));
  endtask

  task automatic edit(input logic trk, input logic [3:0] step, input logic [2:0] kind);
    edits_sent++;
    send_item(CMD_EDIT, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), trk, step, kind);
  endtask

  task automatic run_ticks(input int n);
    repeat (n) begin
      tick(1'b0, 1'b0);
      tick(1'b1, 1'b0);
    end
  endtask

  // hold the sender until every result is back
  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (gate_queue.size() != 0);
  endtask

  task automatic cfg_write(input logic sel, input len_t value);
    logic [DATA_W-1:0] word;
    word = ($urandom & ~32'h1f) | DATA_W'(value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    track_len_reg[sel] = value;
    length_writes++;
    @(posedge clk);
  endtask

  task automatic set_lengths(input len_t len_a, input len_t len_b);
    drain();
    repeat (2) @(posedge clk);
    cfg_write(REG_LEN_A, len_a);
    cfg_write(REG_LEN_B, len_b);
  endtask

  task automatic test_directed;
    edit(TRACK_A, 4'd1, KIND_PLAIN);
    edit(TRACK_A, 4'd2, KIND_SKIP_MIN);
    edit(TRACK_A, 4'd3, KIND_SKIP3);
    edit(TRACK_A, 4'd4, KIND_SKIP4);
    edit(TRACK_B, 4'd0, KIND_EMPTY);     // empty kind places plain
    edit(TRACK_B, 4'd3, KIND_SKIP_MAX);
    edit(TRACK_B, 4'd1, KIND_BAD7);
    edit(TRACK_B, 4'd15, KIND_BAD6);     // beyond track length, stored
    tick(1'b1, 1'b0);
    tick(1'b0, 1'b0);
    tick(1'b1, 1'b0);
    edit(TRACK_A, 4'd2, KIND_PLAIN);     // skip counter mid-count removes
    tick(1'b0, 1'b0);
    tick(1'b1, 1'b0);
    tick(1'b1, 1'b0);                    // held high, no advance
    tick(1'b0, 1'b1);
    tick(1'b1, 1'b1);
    edit(TRACK_A, 4'd0, KIND_SKIP_MIN);
    tick(1'b0, 1'b0);
    tick(1'b1, 1'b1);                    // reset onto an active skip step
    edit(TRACK_A, 4'd1, KIND_PLAIN);     // active step removed
    run_ticks(3);
  endtask

  task automatic test_lengths;
    set_lengths(5'd1, 5'd16);
    edit(TRACK_B, 4'd15, KIND_SKIP_MIN);
    run_ticks(20);
    set_lengths(5'd16, 5'd1);
    edit(TRACK_A, 4'd15, KIND_PLAIN);
    run_ticks(18);
    set_lengths(5'd0, 5'd31);
    run_ticks(4);
    set_lengths(5'd31, 5'd0);
    run_ticks(4);
    set_lengths(5'd16, 5'd16);
    run_ticks(12);
    // shrink below the playheads
    set_lengths(5'd3, 5'd2);
    run_ticks(4);
  endtask

  task automatic random_item;
    int r;
    int t;
    r = $urandom_range(0, 99);
    t = $urandom_range(0, 1);
    if (r < 30) begin
      if ($urandom_range(0, 9) < 7)
        edit(1'(t), 4'($urandom_range(0, eff_len(t) - 1)), 3'($urandom_range(0, 7)));
      else
        edit(1'(t), 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)));
    end else if (r < 34) begin
      tick(1'($urandom_range(0, 1)), 1'b1);
    end else if (r < 40) begin
      tick(1'($urandom_range(0, 1)), 1'b0);
    end else begin
      tick(!last_level, 1'b0);
    end
  endtask

  task automatic test_random;
    len_t la;
    len_t lb;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin la = 5'd1;  lb = 5'd16; end
        1: begin la = 5'd16; lb = 5'd1;  end
        2: begin la = 5'd0;  lb = 5'd31; end
        3: begin la = 5'd31; lb = 5'd0;  end
        default: begin
          la = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31)) :
                                             5'($urandom_range(1, 16));
          lb = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31)) :
                                             5'($urandom_range(1, 16));
        end
      endcase
      set_lengths(la, lb);
      for (int i = 0; i < 200; i++) begin
        if (i == 100) drain();
        random_item();
      end
    end
  endtask

  initial begin : main
    int waited;
    for (int t = 0; t < 2; t++) begin
      for (int s = 0; s < MAX_STEPS_DEF; s++) begin
        slot_kind[t][s] = KIND_EMPTY;
        slot_armed[t][s] = 1'b0;
        slot_count[t][s] = '0;
      end
      play_pos[t] = 4'd0;
      edge_seen[t] = 1'b0;
      gate_lvl[t] = 1'b0;
    end
    track_len_reg[0] = LEN_A_RST;
    track_len_reg[1] = LEN_B_RST;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_lengths();
    test_random();
    in_valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (gate_queue.size() != 0 && waited < 10000);
    repeat (4) @(posedge clk);
    if (gate_queue.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, gate_queue.size());
      errors += gate_queue.size();
    end
    $display("tb: %0d ticks (%0d with reset pulse), %0d edits, %0d results checked",
             ticks_sent, resets_sent, edits_sent, results_seen);
    $display("tb: %0d length register writes incl. 0, 1, 16 and 31; %0d errors",
             length_writes, errors);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

### dual_track_skip_step_sequencer.f
+incdir+hw/rtl
hw/rtl/dtss_pkg.sv
hw/rtl/dual_track_skip_step_sequencer.sv
dv/tb.sv
